// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the cluster table RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/fct_pkg.sv -----
// Shared types, codes and constants for the FAT12 cluster table engine.
// No dependencies.
package fct_pkg;

    localparam int FCT_MAX_ENTRIES = 4096;

    localparam int OPC_W = 3;
    localparam int IDX_W = 13;
    localparam int VAL_W = 12;
    localparam int CNT_W = 13;
    localparam int ST_W  = 2;

    localparam logic [OPC_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OPC_W-1:0] OP_READ  = 3'd1;
    localparam logic [OPC_W-1:0] OP_WRITE = 3'd2;
    localparam logic [OPC_W-1:0] OP_COUNT = 3'd3;
    localparam logic [OPC_W-1:0] OP_FIND  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE    = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE      = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_fct_in;

    typedef struct packed {
        logic [VAL_W-1:0] entry_value;
        logic [CNT_W-1:0] free_count;
        logic [ST_W-1:0]  status;
    } t_fct_out;

    // Controller to datapath
    typedef struct packed {
        logic            latch;
        logic            ptr_idx;
        logic            ptr_two;
        logic            ptr_inc;
        logic            rd_hi;
        logic            cap_lo;
        logic            cap_hi;
        logic            wr_load;
        logic            wr_lo;
        logic            wr_hi;
        logic            res_entry;
        logic            res_ptr;
        logic            res_inc;
        logic            st_set;
        logic [ST_W-1:0] st_code;
        logic            out_load;
    } t_fct_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             load_ok;
        logic             not_loaded;
        logic             idx_ok;
        logic             ptr_end;
        logic             entry_zero;
    } t_fct_sts;

endpackage

// ----- rtl/core/fct_datapath.sv -----
// Datapath: packed byte table memory, entry pointer, byte merge and result registers.
// Depends on fct_pkg; driven by fct_ctrl through t_fct_cmd.
module fct_datapath #(
    parameter int MAX_ENTRIES = fct_pkg::FCT_MAX_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fct_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  fct_pkg::t_fct_in              i_in_data,
    input  fct_pkg::t_fct_cmd             i_cmd,
    output fct_pkg::t_fct_sts             o_sts,
    output fct_pkg::t_fct_out             o_out_data
);
    import fct_pkg::*;

    localparam int TABLE_SIZE = (3 * MAX_ENTRIES + 1) / 2;
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [7:0]       mem [TABLE_SIZE];
    logic [7:0]       r_rdata;
    logic [CNT_W-1:0] r_entry_count;
    t_fct_in          r_item;
    logic [CW-1:0]    r_ptr;
    logic [7:0]       r_lo;
    logic [7:0]       r_hi;
    logic [VAL_W-1:0] r_ev;
    logic [CNT_W-1:0] r_fc;
    logic [ST_W-1:0]  r_st;
    t_fct_out         r_out;

    logic [CW-1:0]    n_used;
    logic [CW-2:0]    half;
    logic [AW-1:0]    addr_lo;
    logic [AW-1:0]    addr_hi;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;
    logic             we;
    logic [VAL_W-1:0] entry;

    // Counts above the table depth behave as the table depth
    assign n_used = (r_entry_count > CNT_W'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                          : r_entry_count[CW-1:0];

    // Entry i lives in bytes 3*(i/2) + (i odd) and the byte after it
    assign half    = r_ptr[CW-1:1];
    assign addr_lo = AW'({half, 1'b0}) + AW'(half) + AW'(r_ptr[0]);
    assign addr_hi = addr_lo + AW'(1);
    assign raddr   = i_cmd.rd_hi ? addr_hi : addr_lo;

    assign entry = r_ptr[0] ? {r_hi, r_lo[7:4]} : {r_hi[3:0], r_lo};

    always_comb begin
        we    = i_cmd.wr_load | i_cmd.wr_lo | i_cmd.wr_hi;
        waddr = addr_lo;
        wdata = r_item.value[7:0];
        if (i_cmd.wr_load) begin
            waddr = r_item.index[AW-1:0];
            wdata = r_item.value[7:0];
        end else if (i_cmd.wr_lo) begin
            waddr = addr_lo;
            wdata = r_ptr[0] ? {r_item.value[3:0], r_lo[3:0]} : r_item.value[7:0];
        end else if (i_cmd.wr_hi) begin
            waddr = addr_hi;
            wdata = r_ptr[0] ? r_item.value[11:4] : {r_hi[7:4], r_item.value[11:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.ptr_idx) begin
            r_ptr <= r_item.index[CW-1:0];
        end else if (i_cmd.ptr_two) begin
            r_ptr <= CW'(2);
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_rdata;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rdata;
        end
        if (i_cmd.latch) begin
            r_ev <= '0;
            r_fc <= '0;
            r_st <= ST_OK;
        end else begin
            if (i_cmd.res_entry) begin
                r_ev <= entry;
            end else if (i_cmd.res_ptr) begin
                r_ev <= VAL_W'(r_ptr);
            end
            if (i_cmd.res_inc) begin
                r_fc <= r_fc + CNT_W'(1);
            end
            if (i_cmd.st_set) begin
                r_st <= i_cmd.st_code;
            end
        end
        if (i_cmd.out_load) begin
            r_out.entry_value <= r_ev;
            r_out.free_count  <= r_fc;
            r_out.status      <= r_st;
        end
    end

    assign o_sts.opcode     = r_item.opcode;
    assign o_sts.load_ok    = ({1'b0, r_item.index} < (IDX_W + 1)'(TABLE_SIZE));
    assign o_sts.not_loaded = (n_used == '0);
    assign o_sts.idx_ok     = (r_item.index < IDX_W'(n_used));
    assign o_sts.ptr_end    = (r_ptr >= n_used);
    assign o_sts.entry_zero = (entry == '0);

    assign o_out_data = r_out;

endmodule

// ----- rtl/core/fct_ctrl.sv -----
// Controller: operation sequencer and output handshake for the cluster table engine.
// Depends on fct_pkg and assert_macros.svh; drives fct_datapath through t_fct_cmd.
`include "assert_macros.svh"

module fct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  fct_pkg::t_fct_sts  i_sts,
    output fct_pkg::t_fct_cmd  o_cmd
);
    import fct_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DEC  = 10'b00_0000_0010,
        S_TEST = 10'b00_0000_0100,
        S_LO   = 10'b00_0000_1000,
        S_HI   = 10'b00_0001_0000,
        S_CAP  = 10'b00_0010_0000,
        S_EVAL = 10'b00_0100_0000,
        S_WLO  = 10'b00_1000_0000,
        S_WHI  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    t_fct_cmd cmd;
    logic     in_xfer;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        cmd.st_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                unique case (i_sts.opcode) inside
                    OP_LOAD: begin
                        if (i_sts.load_ok) begin
                            cmd.wr_load = 1'b1;
                        end else begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end
                    end
                    OP_READ, OP_WRITE: begin
                        if (i_sts.not_loaded) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_NOT_LOADED;
                        end else if (!i_sts.idx_ok) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end else begin
                            cmd.ptr_idx = 1'b1;
                            n_state     = S_LO;
                        end
                    end
                    OP_COUNT, OP_FIND: begin
                        if (i_sts.not_loaded) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_NOT_LOADED;
                        end else begin
                            cmd.ptr_two = 1'b1;
                            n_state     = S_TEST;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_TEST: begin
                if (i_sts.ptr_end) begin
                    if (i_sts.opcode == OP_FIND) begin
                        cmd.st_set  = 1'b1;
                        cmd.st_code = ST_NO_FREE;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_LO;
                end
            end
            S_LO: n_state = S_HI;
            S_HI: begin
                cmd.rd_hi  = 1'b1;
                cmd.cap_lo = 1'b1;
                n_state    = S_CAP;
            end
            S_CAP: begin
                cmd.cap_hi = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                unique case (i_sts.opcode) inside
                    OP_READ:  cmd.res_entry = 1'b1;
                    OP_WRITE: n_state = S_WLO;
                    OP_COUNT: begin
                        cmd.res_inc = i_sts.entry_zero;
                        cmd.ptr_inc = 1'b1;
                        n_state     = S_TEST;
                    end
                    OP_FIND: begin
                        if (i_sts.entry_zero) begin
                            cmd.res_ptr = 1'b1;
                        end else begin
                            cmd.ptr_inc = 1'b1;
                            n_state     = S_TEST;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WLO: begin
                cmd.wr_lo = 1'b1;
                n_state   = S_WHI;
            end
            S_WHI: begin
                cmd.wr_hi = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // result slot is free once the previous one transfers
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `FCT_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, in_xfer, r_state == S_DEC)
    `FCT_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
    `FCT_ASSERT_IMPL(a_eval_after_cap, i_clk, i_rst_n, r_state == S_EVAL, $past(r_state) == S_CAP)
    `FCT_ASSERT_NEXT(a_write_pair, i_clk, i_rst_n, cmd.wr_lo, r_state == S_WHI)

endmodule

// ----- rtl/core/fat12_cluster_table_engine_unit.sv -----
// Top level of the FAT12 cluster table engine: controller plus datapath.
// Depends on fct_pkg, fct_ctrl and fct_datapath.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall   | i_in_data   (t_fct_in)
//  result   | out       | o_out_valid / i_out_stall | o_out_data  (t_fct_out)
//  config   | in        | i_cfg_wr_en               | i_cfg_wr_data (entry count)
//
// One item at a time: a load writes one byte, a read fetches an entry's two bytes,
// a write fetches and rewrites them, count and find walk entries from 2 upward and
// a find stops on a free entry. Two byte reads per entry through the one read port.
// Reset clears the controller and entry count; the table is not cleared.
// A new item is taken while a result waits; a stalled result holds the next one
// in its final state.
module fat12_cluster_table_engine_unit #(
    parameter int MAX_ENTRIES = fct_pkg::FCT_MAX_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [fct_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  fct_pkg::t_fct_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output fct_pkg::t_fct_out         o_out_data
);
    import fct_pkg::*;

    t_fct_cmd cmd;
    t_fct_sts sts;

    fct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fct_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the FAT12 cluster table engine: directed and random table traffic,
// each result checked against an in-bench model of the packed byte table.
// Depends on fct_pkg and fat12_cluster_table_engine_unit.
module tb_top;
    import fct_pkg::*;

    localparam int TBL_BYTES = (3 * FCT_MAX_ENTRIES + 1) / 2;
    localparam logic [OPC_W-1:0] OP_TOP = '1;   // highest undefined opcode
    localparam logic [CNT_W-1:0] CNT_TOP = '1;
    localparam int FILL_ENTRIES = 256;          // entries whose bytes are loaded before the mix
    localparam int FILL_BYTES = 3 * FILL_ENTRIES / 2;
    localparam int CHUNKS = 10;
    localparam int CHUNK_ITEMS = 66;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    t_fct_in          in_data = '0;
    logic             out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_fct_out         o_out_data;

    // model state
    logic [7:0]       tbl_model [TBL_BYTES];
    logic [CNT_W-1:0] model_entries = '0;
    t_fct_out         pending_results[$];

    int err_count = 0;
    bit idle_en = 1'b1;
    int stall_left = 0;

    always #6 i_clk = ~i_clk;

    fat12_cluster_table_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (o_out_data)
    );

    function automatic int eff_entries();
        return (model_entries > FCT_MAX_ENTRIES) ? FCT_MAX_ENTRIES : int'(model_entries);
    endfunction

    function automatic logic [VAL_W-1:0] fat_entry(int i);
        int j;
        if (i % 2 == 1) begin
            j = (3 * i + 1) / 2;
            return {tbl_model[j], tbl_model[j-1][7:4]};
        end
        j = 3 * i / 2;
        return {tbl_model[j+1][3:0], tbl_model[j]};
    endfunction

    // only the entry's own 12 bits change; the shared byte keeps the neighbor's nibble
    function automatic void fat_store(int i, logic [VAL_W-1:0] v);
        int j;
        if (i % 2 == 1) begin
            j = (3 * i + 1) / 2;
            tbl_model[j] = v[11:4];
            tbl_model[j-1][7:4] = v[3:0];
        end else begin
            j = 3 * i / 2;
            tbl_model[j] = v[7:0];
            tbl_model[j+1][3:0] = v[11:8];
        end
    endfunction

    // true when a walk from entry 2 meets a free entry inside the loaded low entries
    function automatic bit free_in_fill();
        for (int e = 2; e < FILL_ENTRIES; e++) begin
            if (fat_entry(e) == '0) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_fct_out fat_apply(t_fct_in it);
        t_fct_out r;
        int n;
        int j;
        bit found;
        r = '0;
        found = 1'b0;
        n = eff_entries();
        if (it.opcode == OP_LOAD) begin
            if (it.index < TBL_BYTES) tbl_model[it.index] = it.value[7:0];
            else r.status = ST_RANGE;
        end else if (it.opcode <= OP_FIND) begin
            if (n == 0) begin
                r.status = ST_NOT_LOADED;
            end else if (it.opcode == OP_READ || it.opcode == OP_WRITE) begin
                if (it.index >= n) r.status = ST_RANGE;
                else if (it.opcode == OP_READ) r.entry_value = fat_entry(int'(it.index));
                else fat_store(int'(it.index), it.value);
            end else if (it.opcode == OP_COUNT) begin
                for (j = 2; j < n; j++) begin
                    if (fat_entry(j) == '0) r.free_count = r.free_count + 1'b1;
                end
            end else begin
                r.status = ST_NO_FREE;
                for (j = 2; j < n && !found; j++) begin
                    if (fat_entry(j) == '0) begin
                        found = 1'b1;
                        r.entry_value = VAL_W'(j);
                        r.status = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_fct_in mk_item(logic [OPC_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic [VAL_W-1:0] val);
        t_fct_in it;
        it.opcode = op;
        it.index = idx;
        it.value = val;
        return it;
    endfunction

    // mostly well-formed accesses inside the loaded part of the live table,
    // some out-of-range noise
    function automatic t_fct_in random_item(int n);
        t_fct_in it;
        int r;
        int lim;
        lim = (n < FILL_ENTRIES) ? n : FILL_ENTRIES;
        it.value = VAL_W'($urandom);
        it.index = IDX_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20) begin
            it.opcode = OP_LOAD;
            r = $urandom_range(0, 9);
            if (r < 5) it.index = IDX_W'($urandom_range(0, 3 * n / 2 + 2));
            else if (r < 8) it.index = IDX_W'($urandom_range(0, TBL_BYTES - 1));
            if ($urandom_range(0, 4) == 0) it.value[7:0] = '0;
        end else if (r < 70) begin
            it.opcode = (r < 45) ? OP_READ : OP_WRITE;
            if (n > 0 && $urandom_range(0, 99) < 85) it.index = IDX_W'($urandom_range(0, lim - 1));
            else if ($urandom_range(0, 1) == 0) it.index = IDX_W'(n + $urandom_range(0, 3));
            else it.index = IDX_W'($urandom_range(n, (1 << IDX_W) - 1));
            r = $urandom_range(0, 9);
            if (r < 3) it.value = '0;
            else if (r == 3) it.value = '1;
        end else if (r < 80) begin
            it.opcode = OP_COUNT;
        end else if (r < 92) begin
            it.opcode = OP_FIND;
        end else begin
            it.opcode = OPC_W'($urandom_range(OP_FIND + 1, OP_TOP));
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
        $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
        err_count++;
    endtask

    task automatic send_item(t_fct_in it);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(fat_apply(it));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic write_entry_count(logic [CNT_W-1:0] v);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        model_entries = v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_unloaded();
        send_item(mk_item(OP_READ, '0, '0));
        send_item(mk_item(OP_WRITE, '0, '1));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_FIND, '1, '1));
        send_item(mk_item(OP_LOAD, IDX_W'(TBL_BYTES), 12'h0A5));
        send_item(mk_item(OP_LOAD, '1, '1));
        send_item(mk_item(OPC_W'(OP_FIND + 1), IDX_W'($urandom), VAL_W'($urandom)));
        send_item(mk_item(OPC_W'(OP_FIND + 2), IDX_W'($urandom), VAL_W'($urandom)));
        send_item(mk_item(OP_TOP, '1, '1));
    endtask

    task automatic test_packed_entries();
        logic [7:0] seed_bytes [6] = '{8'hF0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
        drain_results();
        write_entry_count(CNT_W'(4));
        for (int b = 0; b < 6; b++)
            send_item(mk_item(OP_LOAD, IDX_W'(b), {4'($urandom), seed_bytes[b]}));
        for (int e = 0; e < 5; e++)
            send_item(mk_item(OP_READ, IDX_W'(e), '0));
        send_item(mk_item(OP_WRITE, IDX_W'(4), 12'h123));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_WRITE, IDX_W'(2), '1));
        send_item(mk_item(OP_WRITE, IDX_W'(3), 12'hA5C));
        send_item(mk_item(OP_READ, IDX_W'(2), '0));
        send_item(mk_item(OP_READ, IDX_W'(3), '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_WRITE, IDX_W'(1), '0));
        send_item(mk_item(OP_READ, IDX_W'(0), '0));
        send_item(mk_item(OP_WRITE, IDX_W'(3), '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_LOAD, IDX_W'(TBL_BYTES - 1), VAL_W'($urandom)));
    endtask

    // tables of one to three entries, then none: the free walk from entry 2 is empty or tiny
    task automatic test_short_tables();
        drain_results();
        write_entry_count(CNT_W'(1));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_READ, IDX_W'(0), '0));
        send_item(mk_item(OP_READ, IDX_W'(1), '0));
        drain_results();
        write_entry_count(CNT_W'(2));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_WRITE, IDX_W'(1), VAL_W'($urandom)));
        send_item(mk_item(OP_READ, IDX_W'(1), '0));
        drain_results();
        write_entry_count(CNT_W'(3));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_WRITE, IDX_W'(2), '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_COUNT, '0, '0));
        drain_results();
        write_entry_count('0);
        send_item(mk_item(OP_READ, IDX_W'(0), '0));
    endtask

    // load the low entries and the last two bytes; every walk and access stays
    // inside loaded bytes, a long find stops on a free entry near the start
    task automatic test_full_table();
        logic [VAL_W-1:0] v;
        for (int b = 0; b < FILL_BYTES; b++) begin
            v = VAL_W'($urandom);
            if (v[7:0] == 8'h00) v[0] = 1'b1;   // nonzero bytes leave no free entry
            send_item(mk_item(OP_LOAD, IDX_W'(b), v));
        end
        send_item(mk_item(OP_LOAD, IDX_W'(TBL_BYTES - 2), VAL_W'($urandom)));
        send_item(mk_item(OP_LOAD, IDX_W'(TBL_BYTES - 1), VAL_W'($urandom)));
        drain_results();
        write_entry_count(CNT_W'(FILL_ENTRIES));
        send_item(mk_item(OP_COUNT, '0, '0));
        send_item(mk_item(OP_FIND, '0, '0));
        drain_results();
        write_entry_count(CNT_TOP);
        send_item(mk_item(OP_READ, IDX_W'(FCT_MAX_ENTRIES - 1), '0));
        send_item(mk_item(OP_READ, IDX_W'(FCT_MAX_ENTRIES), '0));
        send_item(mk_item(OP_WRITE, IDX_W'(FCT_MAX_ENTRIES - 1), '0));
        send_item(mk_item(OP_READ, IDX_W'(FCT_MAX_ENTRIES - 1), '0));
        drain_results();
        write_entry_count(CNT_W'(FCT_MAX_ENTRIES + 1));
        send_item(mk_item(OP_WRITE, IDX_W'(2), '0));
        send_item(mk_item(OP_FIND, '0, '0));
        send_item(mk_item(OP_READ, '1, '0));
    endtask

    task automatic test_random_mix();
        logic [CNT_W-1:0] setting;
        t_fct_in it;
        int walk_budget;
        int n;
        for (int c = 0; c < CHUNKS; c++) begin
            case (c)
                0: setting = '0;
                1: setting = CNT_W'(1);
                2: setting = CNT_W'($urandom_range(2, 3));
                3: setting = CNT_W'($urandom_range(4, 40));
                4: setting = CNT_TOP;
                5: setting = CNT_W'($urandom_range(4, 200));
                6: setting = CNT_W'(FCT_MAX_ENTRIES);
                7: setting = CNT_W'($urandom_range(FCT_MAX_ENTRIES + 1, CNT_TOP - 1));
                default: setting = CNT_W'($urandom_range(4, 64));
            endcase
            drain_results();
            idle_en = (c < CHUNKS - 2);
            write_entry_count(setting);
            n = eff_entries();
            walk_budget = 3;
            repeat (CHUNK_ITEMS) begin
                it = random_item(n);
                if ((it.opcode == OP_COUNT || it.opcode == OP_FIND) && n > FILL_ENTRIES) begin
                    // a walk past the loaded entries must stop on a free one first
                    if (it.opcode == OP_FIND && walk_budget > 0 && free_in_fill()) begin
                        walk_budget--;
                    end else begin
                        it.opcode = OP_READ;
                        it.index = IDX_W'($urandom_range(0, FILL_ENTRIES - 1));
                    end
                end
                if (idle_en && $urandom_range(0, 49) == 0) drain_results();
                send_item(it);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : chk_results
        t_fct_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", '0, 32'(o_out_data));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.entry_value !== want.entry_value)
                    report_mismatch("entry_value", 32'(want.entry_value),
                                    32'(o_out_data.entry_value));
                if (o_out_data.free_count !== want.free_count)
                    report_mismatch("free_count", 32'(want.free_count),
                                    32'(o_out_data.free_count));
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_out_data.status));
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_unloaded();
        test_packed_entries();
        test_short_tables();
        test_full_table();
        test_random_mix();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fct_pkg.sv
rtl/core/fct_datapath.sv
rtl/core/fct_ctrl.sv
rtl/core/fat12_cluster_table_engine_unit.sv
dv/tb_top.sv
